// ===== rtl/joint_limit_damping_weight_unit_assert.svh =====
// assertion macros for the joint limit damping weight unit
`ifndef JOINT_LIMIT_DAMPING_WEIGHT_UNIT_ASSERT_SVH
`define JOINT_LIMIT_DAMPING_WEIGHT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define JLDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JLDW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define JLDW_ASSERT(lbl, prop, msg)
`define JLDW_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/jldw_pkg.sv =====
package jldw_pkg;

  typedef enum logic [1:0] {
    REGION_OUTSIDE = 2'd0,
    REGION_FREE    = 2'd1,
    REGION_LOWER   = 2'd2,
    REGION_UPPER   = 2'd3
  } region_e;

  typedef struct packed {
    logic [15:0] gain;
    region_e     region;
    logic        last;
    logic        bypass;
  } side_t;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam longint      ONE_Q30 = 64'sd1073741824;
  localparam logic [15:0] AF_RESET = 16'd6554;

endpackage

// ===== rtl/jldw_div.sv =====
module jldw_div #(
  parameter int QW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [15:0]      in_depth_i,
  input  logic [15:0]      in_divisor_i,
  input  jldw_pkg::side_t  in_side_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [QW-1:0]    out_quot_o,
  output jldw_pkg::side_t  out_side_o
);

  logic [QW-1:0]   v_q;
  logic [QW:0]     en;
  logic [15:0]     rem_q  [QW];
  logic [15:0]     dvs_q  [QW];
  logic [QW-1:0]   quot_q [QW];
  jldw_pkg::side_t side_q [QW];

  assign en[QW] = out_ready_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [16:0]   part;
    logic [15:0]   dvs_in;
    logic [QW-1:0] quot_in;
    jldw_pkg::side_t side_in;
    logic          vin;
    logic          qbit;

    assign en[k] = !v_q[k] || en[k+1];

    if (k == 0) begin : g_first
      assign part    = {1'b0, in_depth_i};
      assign dvs_in  = in_divisor_i;
      assign quot_in = '0;
      assign side_in = in_side_i;
      assign vin     = in_valid_i;
    end else begin : g_next
      assign part    = {rem_q[k-1], 1'b0};
      assign dvs_in  = dvs_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
      assign vin     = v_q[k-1];
    end

    assign qbit = (part >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && vin) begin
        rem_q[k]  <= qbit ? 16'(part - {1'b0, dvs_in}) : part[15:0];
        dvs_q[k]  <= dvs_in;
        quot_q[k] <= {quot_in[QW-2:0], qbit};
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[QW-1];
  assign out_quot_o  = quot_q[QW-1];
  assign out_side_o  = side_q[QW-1];

endmodule

// ===== rtl/joint_limit_damping_weight_unit.sv =====
// joint limit damping weight unit
// input stream: one joint per beat, s_axis_tdata carries position, lower limit,
// upper limit and max gain; s_axis_tlast marks the final joint of a vector
// output stream: one beat per input beat, in order, m_axis_tdata is the weight
// (Q8.8), m_axis_tuser the region code, m_axis_tlast copies the input tlast
// cfg_we_i / cfg_wdata_i write the activation fraction (Q0.16); the user must do so only while idle (not enforced)
// pipeline: buffer multiply, region compare, ANGLE_WIDTH + 1 divider stages
// (one quotient bit each), cosine table read, gain multiply and the output
// register
// throughput is one beat per cycle unless the receiver stalls, set by the one-bit-per-stage divider
// reset empties the pipeline and loads the activation fraction with 6554
// when the receiver stalls, the pipeline keeps filling its empty stages and
// s_axis_tready drops only once every stage holds a beat
module joint_limit_damping_weight_unit #(
  parameter int COS_TABLE_ENTRIES = 256,
  parameter int ANGLE_WIDTH       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // position, lower_limit, upper_limit, max_gain
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // weight
  output logic [1:0]  m_axis_tuser,  // region
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int QW  = ANGLE_WIDTH + 1;
  localparam int LW  = $clog2(COS_TABLE_ENTRIES);
  localparam int IW  = LW + 1;
  localparam int SW  = QW + LW + 1;
  localparam logic [SW-1:0] HALF_ANGLE = SW'(1) << (ANGLE_WIDTH - 1);
  localparam logic [SW-1:0] TABLE_N    = SW'(COS_TABLE_ENTRIES);
  localparam logic [IW-1:0] IDX_MAX    = IW'(COS_TABLE_ENTRIES);

  function automatic logic [16:0] rc_entry(input int i);
    longint unsigned j, x, x2, term;
    longint sum, h;
    j = (i <= COS_TABLE_ENTRIES - i) ? 64'(i) : 64'(COS_TABLE_ENTRIES - i);
    x = (j * jldw_pkg::PI_Q30) / COS_TABLE_ENTRIES;
    x2 = (x * x) >> 30;
    term = 64'(jldw_pkg::ONE_Q30);
    sum = jldw_pkg::ONE_Q30;
    for (int k = 1; k <= 9; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (64'(i) != j) sum = -sum;
    h = (jldw_pkg::ONE_Q30 + sum) / 2;
    if (h < 0) h = 0;
    if (h > jldw_pkg::ONE_Q30) h = jldw_pkg::ONE_Q30;
    return 17'((h + 8192) >>> 14);
  endfunction

  logic [16:0] rom_w [COS_TABLE_ENTRIES+1];
  for (genvar g = 0; g <= COS_TABLE_ENTRIES; g++) begin : g_rom
    assign rom_w[g] = rc_entry(g);
  end

  logic [15:0] af_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= jldw_pkg::AF_RESET;
    end else if (cfg_we_i) begin
      af_q <= cfg_wdata_i;
    end
  end

  // stage 1: buffers
  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  logic        en1, en2, en3, en4, en5;
  logic signed [15:0] p1_q, lo1_q, up1_q;
  logic [15:0] g1_q, bl1_q, bu1_q;
  logic        last1_q;
  logic signed [15:0] in_p, in_lo, in_up;
  logic [15:0] abs_lo, abs_up;
  logic [32:0] prod_lo, prod_up;

  assign in_p   = s_axis_tdata[15:0];
  assign in_lo  = s_axis_tdata[31:16];
  assign in_up  = s_axis_tdata[47:32];
  assign abs_lo = in_lo[15] ? 16'(~in_lo + 16'd1) : in_lo;
  assign abs_up = in_up[15] ? 16'(~in_up + 16'd1) : in_up;
  assign prod_lo = 33'(abs_lo * af_q) + 33'd32768;
  assign prod_up = 33'(abs_up * af_q) + 33'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      p1_q    <= in_p;
      lo1_q   <= in_lo;
      up1_q   <= in_up;
      g1_q    <= s_axis_tdata[63:48];
      last1_q <= s_axis_tlast;
      bl1_q   <= prod_lo[31:16];
      bu1_q   <= prod_up[31:16];
    end
  end

  // stage 2: region, depth and divisor
  logic signed [17:0] lo_plus, up_minus, p_x, lo_x, up_x;
  logic signed [17:0] dl, du;
  logic        outside, free, lower;
  jldw_pkg::side_t side2_d, side2_q;
  logic [15:0] depth2_d, depth2_q, dvs2_d, dvs2_q;

  assign p_x      = 18'(p1_q);
  assign lo_x     = 18'(lo1_q);
  assign up_x     = 18'(up1_q);
  assign lo_plus  = lo_x + $signed({2'b00, bl1_q});
  assign up_minus = up_x - $signed({2'b00, bu1_q});
  assign outside  = (p_x < lo_x) || (p_x > up_x);
  assign free     = (lo_plus < p_x) && (p_x < up_minus);
  assign lower    = (p_x <= lo_plus);
  assign dl       = p_x - lo_x;
  assign du       = up_x - p_x;

  always_comb begin
    side2_d.gain = g1_q;
    side2_d.last = last1_q;
    depth2_d     = lower ? dl[15:0] : du[15:0];
    dvs2_d       = lower ? bl1_q : bu1_q;
    priority if (outside) begin
      side2_d.region = jldw_pkg::REGION_OUTSIDE;
    end else if (free) begin
      side2_d.region = jldw_pkg::REGION_FREE;
    end else if (lower) begin
      side2_d.region = jldw_pkg::REGION_LOWER;
    end else begin
      side2_d.region = jldw_pkg::REGION_UPPER;
    end
    side2_d.bypass = outside || free || (dvs2_d == 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      side2_q  <= side2_d;
      depth2_q <= depth2_d;
      dvs2_q   <= dvs2_d;
    end
  end

  // divider
  logic            dv_ready, dv_valid;
  logic [QW-1:0]   dv_quot;
  jldw_pkg::side_t dv_side;

  jldw_div #(.QW(QW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_ready_o  (dv_ready),
    .in_depth_i  (depth2_q),
    .in_divisor_i(dvs2_q),
    .in_side_i   (side2_q),
    .out_valid_o (dv_valid),
    .out_ready_i (en3),
    .out_quot_o  (dv_quot),
    .out_side_o  (dv_side)
  );

  // stage 3: table index and lookup
  logic [SW-1:0]   idx_sum;
  logic [IW-1:0]   idx_raw, idx;
  logic [16:0]     ent3_q;
  jldw_pkg::side_t side3_q;

  assign idx_sum = SW'(dv_quot) * TABLE_N + HALF_ANGLE;
  assign idx_raw = IW'(idx_sum >> ANGLE_WIDTH);
  assign idx     = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && dv_valid) begin
      ent3_q  <= rom_w[idx];
      side3_q <= dv_side;
    end
  end

  // stage 4: gain multiply
  logic [32:0]     prod4_q;
  jldw_pkg::side_t side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      prod4_q <= 33'(side3_q.gain * ent3_q);
      side4_q <= side3_q;
    end
  end

  // stage 5: rounding, selection and output register
  logic [32:0] rnd;
  logic [15:0] w5_d, w5_q;
  jldw_pkg::region_e reg5_q;
  logic        last5_q;

  assign rnd = prod4_q + 33'd32768;

  always_comb begin
    if (side4_q.region == jldw_pkg::REGION_FREE) begin
      w5_d = 16'd0;
    end else if (side4_q.bypass) begin
      w5_d = side4_q.gain;
    end else begin
      w5_d = rnd[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      w5_q    <= w5_d;
      reg5_q  <= side4_q.region;
      last5_q <= side4_q.last;
    end
  end

  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || dv_ready;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = w5_q;
  assign m_axis_tuser  = reg5_q;
  assign m_axis_tlast  = last5_q;

`include "joint_limit_damping_weight_unit_assert.svh"

  `JLDW_ASSERT(a_free_zero, m_axis_tvalid && (m_axis_tuser == jldw_pkg::REGION_FREE) |-> m_axis_tdata == 16'd0, "free zone weight not zero")
  `JLDW_ASSERT(a_quot_range, dv_valid && !dv_side.bypass |-> dv_quot <= (QW'(1) << ANGLE_WIDTH), "angle beyond pi in a ramp")
  `JLDW_ASSERT_NEVER(a_stall_full, !s_axis_tready && !m_axis_tvalid, "input stalled with empty output")

endmodule
